>>> src/spts_pkg.sv
// Shared types, constants and the quarter-wave sine function of the
// stereo panned tone sequencer. Used by spts_ctrl, spts_datapath and the top level.
package spts_pkg;

  localparam int DEF_POINT_DEPTH    = 32;
  localparam int DEF_PHASE_BITS     = 32;
  localparam int DEF_SINE_ADDR_BITS = 10;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic REG_SAMPLES_PER_STEP = 1'b0;
  localparam logic REG_POINT_COUNT      = 1'b1;

  localparam logic [15:0] SPS_RESET = 16'd11025;

  localparam logic [15:0] VALUE_MIN  = 16'd2560;
  localparam logic [15:0] VALUE_MAX  = 16'd25600;
  localparam logic [15:0] VALUE_BIAS = 16'd3200;

  // The increment is (value + 3200) * 2^(PHASE_BITS-6) / 19845, rounded.
  localparam logic [63:0] INC_DIV     = 64'd19845;
  localparam int          RECIP_SHIFT = 45;
  localparam logic [30:0] RECIP       = 31'((64'd1 << RECIP_SHIFT) / INC_DIV);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic load_write;
    logic tick_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done_now;
    logic out_free;
  } status_t;

  // Magnitude of the sine at quarter-wave step m, unsigned Q0.15, from an
  // eleventh-order Taylor series in Q30.
  function automatic logic [14:0] sine_mag(input int unsigned m, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(m) * HALF_PI_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

>>> src/spts_ctrl.sv
// Sequencer of the stereo panned tone sequencer: item handshake and the
// per-tick step order. Depends on spts_pkg.
module spts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               func,
  output logic               item_stall,
  input  spts_pkg::status_t  status,
  output spts_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ROUND,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;

  assign accept         = (state == ST_IDLE) && item_valid;
  assign item_stall     = (state != ST_IDLE);
  assign cmd.load_write = accept && (func == spts_pkg::FUNC_LOAD);
  assign cmd.tick_start = accept && (func == spts_pkg::FUNC_TICK);
  assign cmd.emit       = (state == ST_EMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.tick_start) begin
            state <= status.done_now ? ST_EMIT : ST_CLAMP;
          end
        end
        ST_CLAMP: state <= ST_MUL_A;
        ST_MUL_A: state <= ST_MUL_B;
        ST_MUL_B: state <= ST_MUL_C;
        ST_MUL_C: state <= ST_ROUND;
        ST_ROUND: state <= ST_EMIT;
        ST_EMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tick_blocks_next: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_start |=> item_stall)
    else $error("a new item was taken right after a tick");

endmodule

>>> src/spts_datapath.sv
// Datapath of the stereo panned tone sequencer: configuration, point memory,
// oscillator, pan and volume scaling and the result register. Depends on spts_pkg.
module spts_datapath #(
  parameter int POINT_DEPTH    = spts_pkg::DEF_POINT_DEPTH,
  parameter int PHASE_BITS     = spts_pkg::DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = spts_pkg::DEF_SINE_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  spts_pkg::cmd_t     cmd,
  output spts_pkg::status_t  status,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [4:0]         point_index,
  input  logic [15:0]        point_value,
  input  logic signed [15:0] pan_x,
  input  logic signed [15:0] height_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               finished,
  output logic [5:0]         current_point
);

  localparam int ADDR_W  = $clog2(POINT_DEPTH);
  localparam int QBITS   = SINE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int M_W     = QBITS + 1;
  localparam logic [PHASE_BITS-1:0] INC_SCALE =
    PHASE_BITS'((64'd1 << (PHASE_BITS - 6)) / spts_pkg::INC_DIV);
  localparam logic [14:0] INC_REM =
    15'((64'd1 << (PHASE_BITS - 6)) % spts_pkg::INC_DIV);

  logic [15:0]           samples_per_step;
  logic [5:0]            point_count;
  logic [PHASE_BITS-1:0] phase;
  logic [15:0]           tick_counter;
  logic [5:0]            pos;
  logic                  done;

  logic [47:0]           point_mem [POINT_DEPTH];
  logic [47:0]           point_rd;
  logic                  load_ok;

  logic [14:0]           sine_rom [QUARTER+1];
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [1:0]            quad;
  logic [QBITS-1:0]      sine_off;
  logic [M_W-1:0]        sine_idx;
  logic [14:0]           sine_mag;
  logic                  sine_neg;

  logic [15:0]           rd_value;
  logic signed [15:0]    rd_pan;
  logic signed [15:0]    rd_height;
  logic [15:0]           value_c;
  logic signed [15:0]    pan_c;
  logic signed [16:0]    gain_l_s;
  logic signed [16:0]    gain_r_s;
  logic signed [16:0]    hv;
  logic signed [16:0]    hv_c;

  logic [15:0]           gain_l;
  logic [15:0]           gain_r;
  logic [14:0]           vol;
  logic [14:0]           w;
  logic [29:0]           sv;
  logic [29:0]           y;
  logic [PHASE_BITS-1:0] wp;
  logic [45:0]           lmag;
  logic [45:0]           rmag;
  logic [60:0]           q_prod;
  logic [15:0]           q0;
  logic [15:0]           rem;
  logic [14:0]           left_mag;
  logic [14:0]           right_mag;
  logic [46:0]           l_round;
  logic [46:0]           r_round;
  logic [15:0]           q1;
  logic [15:0]           rem1;
  logic                  round_up;
  logic [PHASE_BITS-1:0] inc;
  logic [16:0]           tc_inc;

  assign status.done_now = done || (32'(pos) >= 32'(point_count)) || (32'(pos) >= POINT_DEPTH);
  assign status.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_step <= spts_pkg::SPS_RESET;
      point_count      <= 6'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        spts_pkg::REG_SAMPLES_PER_STEP: samples_per_step <= cfg_data;
        spts_pkg::REG_POINT_COUNT:      point_count      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign load_ok = cmd.load_write && (32'(point_index) < POINT_DEPTH);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      point_mem[ADDR_W'(point_index)] <= {point_value, pan_x, height_y};
    end
    if (cmd.tick_start) begin
      point_rd <= point_mem[ADDR_W'(pos)];
    end
  end

  for (genvar g = 0; g <= QUARTER; g++) begin : g_sine
    assign sine_rom[g] = spts_pkg::sine_mag(g, QBITS);
  end

  assign sine_addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
  assign sine_off  = sine_addr[QBITS-1:0];
  assign sine_idx  = quad[0] ? (M_W'(QUARTER) - {1'b0, sine_off}) : {1'b0, sine_off};

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      sine_mag <= sine_rom[sine_idx];
      sine_neg <= quad[1];
    end
  end

  assign rd_value  = point_rd[47:32];
  assign rd_pan    = $signed(point_rd[31:16]);
  assign rd_height = $signed(point_rd[15:0]);

  always_comb begin
    if (rd_value < spts_pkg::VALUE_MIN) begin
      value_c = spts_pkg::VALUE_MIN;
    end else if (rd_value > spts_pkg::VALUE_MAX) begin
      value_c = spts_pkg::VALUE_MAX;
    end else begin
      value_c = rd_value;
    end
    if (rd_pan < -16'sd16384) begin
      pan_c = -16'sd16384;
    end else if (rd_pan > 16'sd16384) begin
      pan_c = 16'sd16384;
    end else begin
      pan_c = rd_pan;
    end
    gain_l_s = 17'sd16384 - {pan_c[15], pan_c};
    gain_r_s = 17'sd16384 + {pan_c[15], pan_c};
    hv = {rd_height[15], rd_height} + 17'sd16384;
    if (hv < 17'sd0) begin
      hv_c = 17'sd0;
    end else if (hv > 17'sd32768) begin
      hv_c = 17'sd32768;
    end else begin
      hv_c = hv;
    end
  end

  assign q_prod  = 61'(y) * 61'(spts_pkg::RECIP);
  assign l_round = {1'b0, lmag} + (47'd1 << 28);
  assign r_round = {1'b0, rmag} + (47'd1 << 28);

  always_comb begin
    if (rem >= 16'(spts_pkg::INC_DIV)) begin
      q1   = q0 + 16'd1;
      rem1 = rem - 16'(spts_pkg::INC_DIV);
    end else begin
      q1   = q0;
      rem1 = rem;
    end
    round_up = ({1'b0, rem1} << 1) >= 17'(spts_pkg::INC_DIV);
  end

  // Each stage recomputes every cycle from the stage before; the sources
  // hold from the tick capture on, so the chain settles one stage a cycle.
  always_ff @(posedge clk) begin
    gain_l   <= gain_l_s[15:0];
    gain_r   <= gain_r_s[15:0];
    vol      <= hv_c[15:1];
    w        <= 15'(value_c + spts_pkg::VALUE_BIAS);
    sv       <= 30'(sine_mag) * 30'(vol);
    y        <= 30'(w) * 30'(INC_REM);
    wp       <= PHASE_BITS'(w) * INC_SCALE;
    lmag     <= 46'(sv) * 46'(gain_l);
    rmag     <= 46'(sv) * 46'(gain_r);
    q0       <= q_prod[spts_pkg::RECIP_SHIFT +: 16];
    rem      <= 16'(y - 30'(q0) * 30'(spts_pkg::INC_DIV));
    left_mag  <= (l_round[46:29] > 18'd32767) ? 15'h7fff : l_round[43:29];
    right_mag <= (r_round[46:29] > 18'd32767) ? 15'h7fff : r_round[43:29];
    inc      <= wp + PHASE_BITS'(q1) + PHASE_BITS'(round_up);
  end

  assign tc_inc = {1'b0, tick_counter} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      tick_counter <= 16'd0;
      pos          <= 6'd0;
      done         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        done <= status.done_now;
      end
      if (cmd.emit) begin
        result_valid  <= 1'b1;
        current_point <= pos;
        finished      <= done;
        if (done) begin
          left_sample  <= 16'sd0;
          right_sample <= 16'sd0;
        end else begin
          left_sample  <= sine_neg ? -$signed({1'b0, left_mag}) : $signed({1'b0, left_mag});
          right_sample <= sine_neg ? -$signed({1'b0, right_mag}) : $signed({1'b0, right_mag});
          phase <= phase + inc;
          if (tc_inc >= {1'b0, samples_per_step}) begin
            tick_counter <= 16'd0;
            pos          <= pos + 6'd1;
          end else begin
            tick_counter <= tc_inc[15:0];
          end
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("finished flag cleared without reset");

  a_finished_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> left_sample == 16'sd0 && right_sample == 16'sd0)
    else $error("finished result carries a nonzero sample");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !done |=> tick_counter != $past(tick_counter) || pos != $past(pos))
    else $error("played tick did not move the step counter");

endmodule

>>> src/stereo_panned_tone_sequencer.sv
// Stereo panned tone sequencer: a sine oscillator whose pitch, pan and volume
// follow a table of loaded points, one stereo sample per tick item.
// Usage:
//   Items enter on item_valid/item_stall. A load item (func = 0) writes one
//   point into the point memory; an index at or beyond the memory depth is
//   dropped. A tick item (func = 1) plays the current point and gives one
//   result on result_valid/result_stall.
//   A tick passes the step sequencer from acceptance to the result register:
//   memory and sine table read, clamp, three multiply steps and a rounding
//   step, then the result write. Loads sustain one per cycle while no tick
//   is in flight; a new tick is taken only once the last result is written.
//   Once every point has been played, a tick goes straight to the result
//   write and gives a silent sample with finished set.
//   The result register holds while result_stall is high; a new item is taken
//   meanwhile and its result waits in the sequencer until the register frees up.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
//   the user makes them only while no tick is in flight; the block does not check.
//   Reset clears the phase, step counter, play position and finished flag
//   and sets samples_per_step to 11025 and point_count to 0. The point
//   memory is not cleared; only written entries may be played.
module stereo_panned_tone_sequencer #(
  parameter int POINT_DEPTH    = spts_pkg::DEF_POINT_DEPTH,
  parameter int PHASE_BITS     = spts_pkg::DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = spts_pkg::DEF_SINE_ADDR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               func,
  input  logic [4:0]         point_index,
  input  logic [15:0]        point_value,
  input  logic signed [15:0] pan_x,
  input  logic signed [15:0] height_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               finished,
  output logic [5:0]         current_point
);

  spts_pkg::cmd_t    cmd;
  spts_pkg::status_t status;

  spts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .func       (func),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  spts_datapath #(
    .POINT_DEPTH    (POINT_DEPTH),
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .point_index   (point_index),
    .point_value   (point_value),
    .pan_x         (pan_x),
    .height_y      (height_y),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .finished      (finished),
    .current_point (current_point)
  );

endmodule
